// ===== hw/rtl/mmp_pkg.sv =====
// Shared types, constants and saturation helpers for the median motion predictor.
package mmp_pkg;

  // Depth of the per-axis position history.
  localparam int unsigned HistDepth = 4;
  // Width of the stored-sample counter, wide enough to hold HistDepth itself.
  localparam int unsigned CntW = 3;

  // Q16.16 position or speed field.
  typedef logic signed [31:0] data_t;
  // Difference of two positions; one bit wider so it never wraps.
  typedef logic signed [32:0] motion_t;
  // Position plus motion before saturation.
  typedef logic signed [33:0] sum_t;
  // Stored-sample counter.
  typedef logic [CntW-1:0] cnt_t;

  localparam sum_t SumMax = 34'sh0_7FFF_FFFF;
  localparam sum_t SumMin = -34'sh0_8000_0000;

  // Widen a motion value for the saturating adders.
  function automatic sum_t widen_motion(motion_t m);
    return {m[32], m};
  endfunction

  // Widen a position value for the saturating adders.
  function automatic sum_t widen_data(data_t d);
    return {{2{d[31]}}, d};
  endfunction

  // Clamp a wide signed value into the 32-bit field range.
  function automatic data_t sat_sum(sum_t v);
    data_t r;
    if (v > SumMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SumMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mmp_if.sv =====
// Valid/ready channel interfaces for measurement items, result items and the frame-rate write.

// Measurement item channel.
interface mmp_in_if;
  logic                valid;
  logic                ready;
  logic                new_track;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  az_pos;
  logic signed [31:0]  el_pos;

  modport source (output valid, new_track, pos_x, pos_y, az_pos, el_pos, input ready);
  modport sink   (input valid, new_track, pos_x, pos_y, az_pos, el_pos, output ready);
endinterface

// Prediction result item channel.
interface mmp_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pred_x;
  logic signed [31:0]  pred_y;
  logic signed [31:0]  motion_x;
  logic signed [31:0]  motion_y;
  logic signed [31:0]  pred_az;
  logic signed [31:0]  pred_el;
  logic signed [31:0]  speed_az;
  logic signed [31:0]  speed_el;

  modport source (output valid, pred_x, pred_y, motion_x, motion_y, pred_az, pred_el,
                  speed_az, speed_el, input ready);
  modport sink   (input valid, pred_x, pred_y, motion_x, motion_y, pred_az, pred_el,
                  speed_az, speed_el, output ready);
endinterface

// Frame-rate register write channel.
interface mmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/mmp_axis_hist.sv =====
// Four-deep position history of one axis with its median-of-three motion estimate.
module mmp_axis_hist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            clear_i,
  input  mmp_pkg::data_t  pos_i,
  input  mmp_pkg::cnt_t   cnt_i,
  output mmp_pkg::data_t  latest_o,
  output mmp_pkg::motion_t motion_o
);

  mmp_pkg::data_t   hist_q [mmp_pkg::HistDepth];
  mmp_pkg::motion_t diff [mmp_pkg::HistDepth-1];

  // Median of three values, as a min/max network.
  function automatic mmp_pkg::motion_t median3(mmp_pkg::motion_t a, mmp_pkg::motion_t b,
                                               mmp_pkg::motion_t c);
    mmp_pkg::motion_t lo;
    mmp_pkg::motion_t hi;
    mmp_pkg::motion_t m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // Shift register, newest entry at index 0; a new track empties the older entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmp_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (push_i) begin
      hist_q[0] <= pos_i;
      for (int i = 1; i < mmp_pkg::HistDepth; i++) begin
        hist_q[i] <= clear_i ? '0 : hist_q[i-1];
      end
    end
  end

  // Successive differences, kept one bit wider than the positions.
  always_comb begin
    for (int i = 0; i < mmp_pkg::HistDepth - 1; i++) begin
      diff[i] = {hist_q[i][31], hist_q[i]} - {hist_q[i+1][31], hist_q[i+1]};
    end
  end

  // Motion depends on how many samples the track holds.
  always_comb begin
    if (cnt_i < mmp_pkg::cnt_t'(2)) begin
      motion_o = '0;
    end else if (cnt_i < mmp_pkg::cnt_t'(mmp_pkg::HistDepth)) begin
      motion_o = diff[0];
    end else begin
      motion_o = median3(diff[0], diff[1], diff[2]);
    end
  end

  assign latest_o = hist_q[0];

endmodule

// ===== hw/rtl/mmp_speed.sv =====
// Angular speed of one axis: registered motion-times-frame-rate product, then rounding and clamp.
module mmp_speed (
  input  logic             clk_i,
  input  logic             en_i,
  input  mmp_pkg::motion_t motion_i,
  input  logic [31:0]      rate_i,
  output mmp_pkg::data_t   speed_o
);

  logic             neg;
  logic [32:0]      mag_full;
  logic [31:0]      mag;
  logic [63:0]      prod_d;
  logic [63:0]      prod_q;
  logic             neg_q;
  logic             zero_q;
  mmp_pkg::data_t   satm_q;
  logic [63:0]      rnd;
  logic [47:0]      r;

  // Magnitude of the motion always fits 32 bits.
  assign neg      = motion_i[32];
  assign mag_full = neg ? (33'd0 - motion_i) : motion_i;
  assign mag      = mag_full[31:0];
  assign prod_d   = {32'd0, mag} * {32'd0, rate_i};

  // Product register and the flags that steer the output stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= neg;
      zero_q <= (rate_i == 32'd0);
      satm_q <= mmp_pkg::sat_sum(mmp_pkg::widen_motion(motion_i));
    end
  end

  // Round Q32.32 to Q16.16, ties away from zero, then clamp with the sign applied.
  assign rnd = prod_q + 64'h8000;
  assign r   = rnd[63:16];

  always_comb begin
    if (zero_q) begin
      speed_o = satm_q;
    end else if (neg_q) begin
      if (r > 48'h0000_8000_0000) begin
        speed_o = 32'sh8000_0000;
      end else begin
        speed_o = 32'd0 - r[31:0];
      end
    end else begin
      if (r > 48'h0000_7FFF_FFFF) begin
        speed_o = 32'sh7FFF_FFFF;
      end else begin
        speed_o = r[31:0];
      end
    end
  end

endmodule

// ===== hw/rtl/median_motion_predictor_core.sv =====
// Top level of the median motion predictor: history, motion, speed and output stages.

// One measurement item can be accepted in every clock cycle while the output is not
// stalled. The history updates at the accepting clock edge; the item then passes the
// median motion register, the 32x32 frame-rate multiplier register and the output
// register, in that order. Each stage holds its item independently, so a stalled output
// blocks input only once all four stages are full. Positions are signed Q16.16. The frame
// rate is unsigned Q16.16, and zero counts as one frame per period. A set new_track flag
// discards the stored history before the item is stored. The frame-rate register must be
// written only while no item is in flight.
module median_motion_predictor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmp_in_if.sink     in_i,
  mmp_out_if.source  out_o,
  mmp_cfg_if.sink    cfg_i
);

  localparam int unsigned NumAxes = 4;
  localparam int unsigned AxX  = 0;
  localparam int unsigned AxY  = 1;
  localparam int unsigned AxAz = 2;
  localparam int unsigned AxEl = 3;

  logic [31:0]        frame_rate_q;
  mmp_pkg::cnt_t      cnt_q;
  mmp_pkg::cnt_t      cnt_d;
  logic               accept;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               en1, en2, en3, en4;

  mmp_pkg::data_t     pos_in   [NumAxes];
  mmp_pkg::data_t     latest   [NumAxes];
  mmp_pkg::motion_t   motion   [NumAxes];
  mmp_pkg::data_t     lat_q    [NumAxes];
  mmp_pkg::motion_t   mot_q    [NumAxes];

  mmp_pkg::data_t     pred_x_q, pred_y_q, mot_x_q, mot_y_q, pred_az_q, pred_el_q;
  mmp_pkg::data_t     speed_az, speed_el;
  mmp_pkg::data_t     out_pred_x_q, out_pred_y_q, out_mot_x_q, out_mot_y_q;
  mmp_pkg::data_t     out_pred_az_q, out_pred_el_q, out_speed_az_q, out_speed_el_q;

  // Frame-rate register; the write channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rate_q <= '0;
    end else if (cfg_i.valid) begin
      frame_rate_q <= cfg_i.data;
    end
  end

  // Each stage loads when it is empty or its item moves on.
  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Sample counter saturates at the history depth; a new track restarts it.
  always_comb begin
    cnt_d = in_i.new_track ? mmp_pkg::cnt_t'(0) : cnt_q;
    if (cnt_d < mmp_pkg::cnt_t'(mmp_pkg::HistDepth)) begin
      cnt_d = cnt_d + mmp_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Stage one: per-axis history, updated as the item is accepted.
  assign pos_in[AxX]  = in_i.pos_x;
  assign pos_in[AxY]  = in_i.pos_y;
  assign pos_in[AxAz] = in_i.az_pos;
  assign pos_in[AxEl] = in_i.el_pos;

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    mmp_axis_hist u_hist (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .push_i   (accept),
      .clear_i  (in_i.new_track),
      .pos_i    (pos_in[a]),
      .cnt_i    (cnt_q),
      .latest_o (latest[a]),
      .motion_o (motion[a])
    );
  end

  // Stage two: latest position and motion of every axis.
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int a = 0; a < NumAxes; a++) begin
        lat_q[a] <= latest[a];
        mot_q[a] <= motion[a];
      end
    end
  end

  // Stage three: saturated predictions and motions; the speed units register their products.
  always_ff @(posedge clk_i) begin
    if (en3) begin
      pred_x_q  <= mmp_pkg::sat_sum(mmp_pkg::widen_data(lat_q[AxX])
                                    + mmp_pkg::widen_motion(mot_q[AxX]));
      pred_y_q  <= mmp_pkg::sat_sum(mmp_pkg::widen_data(lat_q[AxY])
                                    + mmp_pkg::widen_motion(mot_q[AxY]));
      mot_x_q   <= mmp_pkg::sat_sum(mmp_pkg::widen_motion(mot_q[AxX]));
      mot_y_q   <= mmp_pkg::sat_sum(mmp_pkg::widen_motion(mot_q[AxY]));
      pred_az_q <= mmp_pkg::sat_sum(mmp_pkg::widen_data(lat_q[AxAz])
                                    + mmp_pkg::widen_motion(mot_q[AxAz]));
      pred_el_q <= mmp_pkg::sat_sum(mmp_pkg::widen_data(lat_q[AxEl])
                                    + mmp_pkg::widen_motion(mot_q[AxEl]));
    end
  end

  mmp_speed u_speed_az (
    .clk_i    (clk_i),
    .en_i     (en3),
    .motion_i (mot_q[AxAz]),
    .rate_i   (frame_rate_q),
    .speed_o  (speed_az)
  );

  mmp_speed u_speed_el (
    .clk_i    (clk_i),
    .en_i     (en3),
    .motion_i (mot_q[AxEl]),
    .rate_i   (frame_rate_q),
    .speed_o  (speed_el)
  );

  // Stage four: output register, holds the result item until it is taken.
  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_pred_x_q   <= pred_x_q;
      out_pred_y_q   <= pred_y_q;
      out_mot_x_q    <= mot_x_q;
      out_mot_y_q    <= mot_y_q;
      out_pred_az_q  <= pred_az_q;
      out_pred_el_q  <= pred_el_q;
      out_speed_az_q <= speed_az;
      out_speed_el_q <= speed_el;
    end
  end

  assign out_o.valid    = v4_q;
  assign out_o.pred_x   = out_pred_x_q;
  assign out_o.pred_y   = out_pred_y_q;
  assign out_o.motion_x = out_mot_x_q;
  assign out_o.motion_y = out_mot_y_q;
  assign out_o.pred_az  = out_pred_az_q;
  assign out_o.pred_el  = out_pred_el_q;
  assign out_o.speed_az = out_speed_az_q;
  assign out_o.speed_el = out_speed_el_q;

  // The sample counter never passes the history depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mmp_pkg::cnt_t'(mmp_pkg::HistDepth))
    else $error("sample counter above history depth");

  // A new track leaves exactly one stored sample.
  a_new_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.new_track |=> cnt_q == mmp_pkg::cnt_t'(1))
    else $error("new track did not restart the sample count");

  // A history item held by a busy motion stage stays put, so the history is not overwritten.
  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en2 |=> v1_q && $stable(cnt_q))
    else $error("history changed while its item was still waiting");

endmodule
